/* rtl/pol_pkg.sv */
// Shared constants, codes and types for the positional ordered list.
package pol_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int LEN_W    = 7;
  localparam int STAT_W   = 2;
  localparam int OP_W     = 2;
  // compare width: room for count + 1 and the position field
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // read gather: registered OR over groups of cells
  localparam int GRP_SZ   = 8;
  localparam int NGRP     = (CAPACITY + GRP_SZ - 1) / GRP_SZ;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 112;

  localparam logic [OP_W-1:0] OP_INS_HEAD = 2'd0;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 2'd1;
  localparam logic [OP_W-1:0] OP_INS_POS  = 2'd2;
  localparam logic [OP_W-1:0] OP_DEL_POS  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // broadcast control to every cell of the chain
  typedef struct packed {
    logic             rd;      // capture read gather this cycle
    logic             upd;     // apply shift this cycle
    logic             del;     // 1: delete shift, 0: insert shift
    logic [IDX_W-1:0] idx;     // target slot, 0-based
    logic [IDX_W-1:0] rm_idx;  // slot read for removed value
    logic [IDX_W-1:0] tl_idx;  // slot read for new tail
  } cell_ctrl_t;

endpackage

/* rtl/positional_ordered_list.sv */
// Top level of the positional ordered list: handshake, control and result register.
//
// Ordered store of up to CAPACITY (64) signed 32-bit values, kept in a row of
// cells with entry 0 at the head. Input channel in_*: one beat is one
// operation (insert at head, insert at tail, insert at a 1-based position,
// delete at a 1-based position). Result channel out_*: one beat per input
// beat, in order, carrying status, new length, head, tail and removed value.
// Rejected operations (full store, bad position, empty store) leave the store
// untouched and report it unchanged, with a zero removed value.
//
// Timing: an accepted beat goes to the cell row, where all cells shift at once
// and the two indexed reads (removed slot, new tail slot) are captured by a
// registered OR gather; the output register is loaded in the final step. Beats
// are taken one at a time, as set by the three-step control (take, shift, load)
// with only one beat in flight. in_tready is high only while no beat is in
// flight. If the receiver stalls, the result holds in the final step and no
// new beat is taken until the output register frees up.
//
// Reset (rst_n low, synchronous) empties the list and drops any result in
// flight; cell contents are not cleared since only entries below the count
// are ever reported.
module positional_ordered_list (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] operation, [8:2] position, [40:9] value, [47:41] zero
  input  logic [pol_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] status, [8:2] length, [40:9] head_value, [72:41] tail_value,
  // [104:73] removed_value, [111:105] zero
  output logic [pol_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_FIN = 2'd2;

  logic [1:0] state_r, state_nxt;

  // input fields
  logic [pol_pkg::OP_W-1:0]  in_op;
  logic [pol_pkg::POS_W-1:0] in_pos;
  logic [pol_pkg::VAL_W-1:0] in_val;

  assign in_op  = in_tdata[1:0];
  assign in_pos = in_tdata[8:2];
  assign in_val = in_tdata[40:9];

  // element count
  logic [pol_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  // latched operation
  logic                        ok_r;
  logic                        del_r;
  logic                        ins_end_r;
  logic [pol_pkg::STAT_W-1:0]  stat_r;
  logic [pol_pkg::IDX_W-1:0]   idx_r;
  logic [pol_pkg::IDX_W-1:0]   rm_idx_r;
  logic [pol_pkg::IDX_W-1:0]   tl_idx_r;
  logic [pol_pkg::VAL_W-1:0]   val_r;
  logic [pol_pkg::VAL_W-1:0]   head_r;

  // decode of the incoming beat
  logic [pol_pkg::CMP_W-1:0]   pos_x, cnt_x;
  logic                        full;
  logic                        dec_ok, dec_del, dec_ins_end;
  logic [pol_pkg::STAT_W-1:0]  dec_stat;
  logic [pol_pkg::IDX_W-1:0]   dec_idx, dec_tl_idx;
  logic [pol_pkg::IDX_W-1:0]   cnt_m1, cnt_m2;

  logic in_acc;
  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  assign pos_x  = pol_pkg::CMP_W'(in_pos);
  assign cnt_x  = pol_pkg::CMP_W'(cnt_r);
  assign full   = (cnt_r == pol_pkg::CNT_W'(pol_pkg::CAPACITY));
  assign cnt_m1 = pol_pkg::IDX_W'(cnt_x - pol_pkg::CMP_W'(1));
  assign cnt_m2 = pol_pkg::IDX_W'(cnt_x - pol_pkg::CMP_W'(2));

  always_comb begin
    dec_ok   = 1'b0;
    dec_del  = 1'b0;
    dec_stat = pol_pkg::STAT_OK;
    dec_idx  = pol_pkg::IDX_W'(pos_x - pol_pkg::CMP_W'(1));
    case (in_op)
      pol_pkg::OP_DEL_POS: begin
        dec_del = 1'b1;
        if (cnt_r == '0 || in_pos == '0 || pos_x > cnt_x) begin
          dec_stat = pol_pkg::STAT_RANGE;
        end else begin
          dec_ok = 1'b1;
        end
      end
      pol_pkg::OP_INS_HEAD: begin
        dec_idx = '0;
        if (full) begin
          dec_stat = pol_pkg::STAT_FULL;
        end else begin
          dec_ok = 1'b1;
        end
      end
      pol_pkg::OP_INS_TAIL: begin
        dec_idx = pol_pkg::IDX_W'(cnt_r);
        if (full) begin
          dec_stat = pol_pkg::STAT_FULL;
        end else begin
          dec_ok = 1'b1;
        end
      end
      pol_pkg::OP_INS_POS: begin
        if (full) begin
          dec_stat = pol_pkg::STAT_FULL;
        end else if (in_pos == '0 || pos_x > cnt_x + pol_pkg::CMP_W'(1)) begin
          dec_stat = pol_pkg::STAT_RANGE;
        end else begin
          dec_ok = 1'b1;
        end
      end
      default: begin
        dec_stat = pol_pkg::STAT_RANGE;
      end
    endcase
  end

  // new tail slot, read before the shift
  assign dec_ins_end = dec_ok && !dec_del && (pol_pkg::CMP_W'(dec_idx) == cnt_x);
  assign dec_tl_idx  = (dec_ok && dec_del && dec_idx == cnt_m1) ? cnt_m2 : cnt_m1;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ok_r      <= dec_ok;
      del_r     <= dec_del;
      ins_end_r <= dec_ins_end;
      stat_r    <= dec_stat;
      idx_r     <= dec_idx;
      rm_idx_r  <= dec_idx;
      tl_idx_r  <= dec_tl_idx;
      val_r     <= in_val;
    end
  end

  // cell row
  pol_pkg::cell_ctrl_t       ctrl;
  logic [pol_pkg::VAL_W-1:0] cell0_val, cell1_val, rm_val, tl_val;

  assign ctrl.rd     = (state_r == S_SHIFT);
  assign ctrl.upd    = (state_r == S_SHIFT) && ok_r;
  assign ctrl.del    = del_r;
  assign ctrl.idx    = idx_r;
  assign ctrl.rm_idx = rm_idx_r;
  assign ctrl.tl_idx = tl_idx_r;

  pol_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .ins_val   (val_r),
    .cell0_val (cell0_val),
    .cell1_val (cell1_val),
    .rm_val    (rm_val),
    .tl_val    (tl_val)
  );

  // head after the operation, taken from the cells before they shift
  always_ff @(posedge clk) begin
    if (state_r == S_SHIFT) begin
      if (ok_r && idx_r == '0) begin
        head_r <= del_r ? cell1_val : val_r;
      end else begin
        head_r <= cell0_val;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.upd) begin
      cnt_nxt = del_r ? cnt_r - pol_pkg::CNT_W'(1) : cnt_r + pol_pkg::CNT_W'(1);
    end
  end

  // result assembly
  logic                          out_load;
  logic [pol_pkg::CMP_W-1:0]     len_x;
  logic [pol_pkg::VAL_W-1:0]     res_head, res_tail, res_rm;
  logic [pol_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                          out_tvalid_r, out_tvalid_nxt;

  assign out_load = (state_r == S_FIN) && (!out_tvalid_r || out_tready);
  assign len_x    = pol_pkg::CMP_W'(cnt_r);

  always_comb begin
    res_head = (cnt_r == '0) ? '0 : head_r;
    res_tail = '0;
    if (cnt_r != '0) begin
      res_tail = ins_end_r ? val_r : tl_val;
    end
    res_rm = (ok_r && del_r) ? rm_val : '0;
    out_tdata_nxt = pol_pkg::OUT_TDATA_W'({res_rm, res_tail, res_head,
                                           len_x[pol_pkg::LEN_W-1:0], stat_r});
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

/* rtl/pol_cell.sv */
// One storage cell of the list chain: holds one element, shifts left or right.
module pol_cell (
  input  logic                      clk,
  input  pol_pkg::cell_ctrl_t       ctrl,
  input  logic [pol_pkg::IDX_W-1:0] my_idx,
  input  logic [pol_pkg::VAL_W-1:0] left_val,
  input  logic [pol_pkg::VAL_W-1:0] right_val,
  input  logic [pol_pkg::VAL_W-1:0] ins_val,
  output logic [pol_pkg::VAL_W-1:0] val,
  output logic [pol_pkg::VAL_W-1:0] rm_val,
  output logic [pol_pkg::VAL_W-1:0] tl_val
);

  logic [pol_pkg::VAL_W-1:0] val_r;
  logic [pol_pkg::VAL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.upd) begin
      if (ctrl.del) begin
        if (my_idx >= ctrl.idx) begin
          val_nxt = right_val;
        end
      end else begin
        if (my_idx > ctrl.idx) begin
          val_nxt = left_val;
        end else if (my_idx == ctrl.idx) begin
          val_nxt = ins_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val    = val_r;
  assign rm_val = (my_idx == ctrl.rm_idx) ? val_r : '0;
  assign tl_val = (my_idx == ctrl.tl_idx) ? val_r : '0;

endmodule

/* rtl/pol_chain.sv */
// Row of list cells plus the registered OR gather for the two indexed reads.
module pol_chain (
  input  logic                      clk,
  input  pol_pkg::cell_ctrl_t       ctrl,
  input  logic [pol_pkg::VAL_W-1:0] ins_val,
  output logic [pol_pkg::VAL_W-1:0] cell0_val,
  output logic [pol_pkg::VAL_W-1:0] cell1_val,
  output logic [pol_pkg::VAL_W-1:0] rm_val,
  output logic [pol_pkg::VAL_W-1:0] tl_val
);

  logic [pol_pkg::VAL_W-1:0] cval   [pol_pkg::CAPACITY];
  logic [pol_pkg::VAL_W-1:0] rm_sel [pol_pkg::CAPACITY];
  logic [pol_pkg::VAL_W-1:0] tl_sel [pol_pkg::CAPACITY];

  logic [pol_pkg::VAL_W-1:0] grp_rm_r   [pol_pkg::NGRP];
  logic [pol_pkg::VAL_W-1:0] grp_tl_r   [pol_pkg::NGRP];
  logic [pol_pkg::VAL_W-1:0] grp_rm_nxt [pol_pkg::NGRP];
  logic [pol_pkg::VAL_W-1:0] grp_tl_nxt [pol_pkg::NGRP];

  for (genvar i = 0; i < pol_pkg::CAPACITY; i++) begin : g_cell
    logic [pol_pkg::VAL_W-1:0] left_v;
    logic [pol_pkg::VAL_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cval[i-1];
    end

    if (i == pol_pkg::CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cval[i+1];
    end

    pol_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .my_idx    (pol_pkg::IDX_W'(i)),
      .left_val  (left_v),
      .right_val (right_v),
      .ins_val   (ins_val),
      .val       (cval[i]),
      .rm_val    (rm_sel[i]),
      .tl_val    (tl_sel[i])
    );
  end

  // first level: OR within each group of cells (only one cell is selected)
  always_comb begin
    for (int g = 0; g < pol_pkg::NGRP; g++) begin
      grp_rm_nxt[g] = '0;
      grp_tl_nxt[g] = '0;
      for (int k = 0; k < pol_pkg::GRP_SZ; k++) begin
        if (g * pol_pkg::GRP_SZ + k < pol_pkg::CAPACITY) begin
          grp_rm_nxt[g] = grp_rm_nxt[g] | rm_sel[g * pol_pkg::GRP_SZ + k];
          grp_tl_nxt[g] = grp_tl_nxt[g] | tl_sel[g * pol_pkg::GRP_SZ + k];
        end
      end
    end
  end

  // hold the pre-shift reads until the result is delivered
  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      for (int g = 0; g < pol_pkg::NGRP; g++) begin
        grp_rm_r[g] <= grp_rm_nxt[g];
        grp_tl_r[g] <= grp_tl_nxt[g];
      end
    end
  end

  // second level: OR across groups
  always_comb begin
    rm_val = '0;
    tl_val = '0;
    for (int g = 0; g < pol_pkg::NGRP; g++) begin
      rm_val = rm_val | grp_rm_r[g];
      tl_val = tl_val | grp_tl_r[g];
    end
  end

  assign cell0_val = cval[0];
  assign cell1_val = cval[1];

endmodule

/* rtl/pol_checker.sv */
// Port-level checker for the positional ordered list, bound to the top level.
module pol_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [pol_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pol_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one operation in flight: no beat taken right after another
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input beat taken while busy");

  // only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == pol_pkg::STAT_OK ||
                    out_tdata[1:0] == pol_pkg::STAT_FULL ||
                    out_tdata[1:0] == pol_pkg::STAT_RANGE))
    else $error("undefined status");

  // removed value only on a completed operation
  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != pol_pkg::STAT_OK |-> out_tdata[104:73] == '0)
    else $error("removed value on rejected operation");

  // empty list reports zero head and tail
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8:2] == '0 |-> out_tdata[72:9] == '0)
    else $error("empty list with nonzero head or tail");

endmodule

bind positional_ordered_list pol_checker u_pol_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
